// ===== rtl/iso2ep_pkg.sv =====
// ----------------------------------------------------------------------------
// iso2ep_pkg
// Types, codes and constant tables shared by the timestamp to epoch converter.
// ----------------------------------------------------------------------------
package iso2ep_pkg;

    // One character word on the input side.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } iso2ep_char_t;

    // One result word on the output side.
    typedef struct packed {
        logic [37:0] epoch_seconds;
        logic [2:0]  status;
    } iso2ep_result_t;

    // Which field the parser is collecting.
    typedef enum logic [2:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE,
        PH_SECOND,
        PH_DONE
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_BAD_MONTH = 3'd3;
    localparam logic [2:0] ST_PRE_EPOCH = 3'd4;

    localparam logic [4:0]  MIN_LEN       = 5'd19;
    localparam logic [13:0] BASE_YEAR     = 14'd1970;
    localparam logic [2:0]  YEAR_DIGITS   = 3'd4;
    localparam logic [2:0]  FIELD_DIGITS  = 3'd2;
    localparam logic [6:0]  MONTH_FIRST   = 7'd1;
    localparam logic [6:0]  MONTH_LAST    = 7'd12;
    localparam logic [6:0]  MONTH_MARCH   = 7'd3;
    // Leap days in years 1 through 1969: 492 - 19 + 4.
    localparam logic [8:0]  LEAPS_BEFORE_BASE = 9'd477;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690.
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_SHIFT   = 19;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Days in the year before the first of the given month (1 to 12).
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        begin
            unique case (month)
                4'd1:    d = 9'd0;
                4'd2:    d = 9'd31;
                4'd3:    d = 9'd59;
                4'd4:    d = 9'd90;
                4'd5:    d = 9'd120;
                4'd6:    d = 9'd151;
                4'd7:    d = 9'd181;
                4'd8:    d = 9'd212;
                4'd9:    d = 9'd243;
                4'd10:   d = 9'd273;
                4'd11:   d = 9'd304;
                4'd12:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

    // Separator expected after the field of the given phase.
    function automatic logic [7:0] separator_char(input phase_t phase);
        logic [7:0] s;
        begin
            unique case (phase)
                PH_YEAR, PH_MONTH:   s = CH_DASH;
                PH_DAY:              s = CH_T;
                PH_HOUR, PH_MINUTE:  s = CH_COLON;
                default:             s = 8'h00;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== rtl/iso_timestamp_to_epoch.sv =====
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch
// Parses YYYY-MM-DDTHH:MM:SS one character at a time and returns Unix seconds.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                      Word
//  --------  ---------------------------  ---------------------------------
//  ts        ts_valid, ts_stall, ts_data  char_code, last_char
//  ep        ep_valid, ep_stall, ep_data  epoch_seconds, status
//
//  One character word is taken every cycle while ts_stall is low. The
//  closing character enters a three-stage conversion pipeline (leap counts,
//  day number, seconds product) whose last stage fills the output register.
//  ts_stall rises only when the conversion pipeline is full and the output
//  word is stalled. rst_n clears the parser and all valid flags at once.
//
module iso_timestamp_to_epoch (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       ts_valid,
    output logic                       ts_stall,
    input  iso2ep_pkg::iso2ep_char_t   ts_data,
    output logic                       ep_valid,
    input  logic                       ep_stall,
    output iso2ep_pkg::iso2ep_result_t ep_data
);
    import iso2ep_pkg::*;

    // Parser state.
    phase_t      phase_reg, phase_next, phase_parse;
    logic [13:0] acc_reg, acc_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic        mal_reg, mal_next;

    // Parse-step values after the current character.
    logic [13:0] acc_p;
    logic [2:0]  dcnt_p;
    logic [4:0]  cnt_p;
    logic [13:0] year_p;
    logic [6:0]  month_p, day_p, hour_p, minute_p;
    logic        mal_p;

    logic        take, take_last;
    logic        active, is_digit, run_full, sep_ok, complete;
    logic [2:0]  status_p;

    // Conversion pipeline.
    logic        a_vld_reg, b_vld_reg, c_vld_reg, o_vld_reg;
    logic        a_ready, b_ready, c_ready, o_ready;

    logic [2:0]  a_status_reg;
    logic [13:0] a_year_reg;
    logic [6:0]  a_month_reg, a_day_reg, a_hour_reg, a_minute_reg, a_sec_reg;

    logic [13:0] a_ym1;
    logic [26:0] a_prod_ym1;
    logic [26:0] a_prod_y;
    logic [24:0] a_prod_q4;

    logic [2:0]  b_status_reg;
    logic [13:0] b_year_reg;
    logic [6:0]  b_month_reg, b_day_reg, b_hour_reg, b_minute_reg, b_sec_reg;
    logic [11:0] b_q4_reg;
    logic [7:0]  b_q100_reg;
    logic [5:0]  b_q400_reg;
    logic [7:0]  b_yq100_reg;

    logic [13:0] b_rem100;
    logic        b_leap;
    logic [13:0] b_yoff;
    logic [22:0] b_dpos;
    logic [23:0] b_dneg;
    logic signed [23:0] b_days;
    logic [18:0] b_tod;

    logic [2:0]  c_status_reg;
    logic signed [23:0] c_days_reg;
    logic [18:0] c_tod_reg;
    logic signed [41:0] c_total;

    iso2ep_result_t o_data_reg;
    iso2ep_result_t o_data_next;

    assign o_ready = !o_vld_reg || !ep_stall;
    assign c_ready = !c_vld_reg || o_ready;
    assign b_ready = !b_vld_reg || c_ready;
    assign a_ready = !a_vld_reg || b_ready;

    assign ts_stall  = !a_ready;
    assign take      = ts_valid && a_ready;
    assign take_last = take && ts_data.last_char;

    // ------------------------------------------------------------------
    // Character decode
    // ------------------------------------------------------------------
    always_comb
    begin
        active   = !mal_reg && (phase_reg != PH_DONE);
        is_digit = (ts_data.char_code >= CH_ZERO) && (ts_data.char_code <= CH_NINE);
        run_full = (phase_reg == PH_YEAR) ? (dcnt_reg >= YEAR_DIGITS)
                                          : (dcnt_reg >= FIELD_DIGITS);
        sep_ok   = (ts_data.char_code == separator_char(phase_reg));
    end

    // Next phase after the current character.
    always_comb
    begin
        phase_parse = phase_reg;
        if (active && !is_digit && (dcnt_reg != 3'd0))
        begin
            priority if (phase_reg == PH_SECOND)
            begin
                phase_parse = PH_DONE;
            end
            else if (sep_ok)
            begin
                phase_parse = phase_t'(phase_reg + 3'd1);
            end
            else
            begin
                phase_parse = phase_reg;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = take_last ? PH_YEAR : phase_parse;
        end
    end

    // Field accumulation after the current character.
    always_comb
    begin
        acc_p    = acc_reg;
        dcnt_p   = dcnt_reg;
        year_p   = year_reg;
        month_p  = month_reg;
        day_p    = day_reg;
        hour_p   = hour_reg;
        minute_p = minute_reg;
        mal_p    = mal_reg;
        cnt_p    = (cnt_reg < MIN_LEN) ? cnt_reg + 5'd1 : cnt_reg;

        if (active)
        begin
            priority if (is_digit)
            begin
                if (run_full)
                begin
                    mal_p = 1'b1;
                end
                else
                begin
                    acc_p  = 14'(18'(acc_reg) * 18'd10 + 18'(ts_data.char_code[3:0]));
                    dcnt_p = dcnt_reg + 3'd1;
                end
            end
            else if (dcnt_reg == 3'd0)
            begin
                mal_p = 1'b1;
            end
            else if (phase_reg == PH_SECOND)
            begin
                // Seconds close on any non-digit; the count keeps its value.
            end
            else if (!sep_ok)
            begin
                mal_p = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_YEAR:   year_p   = acc_reg;
                    PH_MONTH:  month_p  = acc_reg[6:0];
                    PH_DAY:    day_p    = acc_reg[6:0];
                    PH_HOUR:   hour_p   = acc_reg[6:0];
                    default:   minute_p = acc_reg[6:0];
                endcase
                acc_p  = 14'd0;
                dcnt_p = 3'd0;
            end
        end

        complete = (phase_parse == PH_DONE) ||
                   ((phase_parse == PH_SECOND) && (dcnt_p != 3'd0));

        priority if (cnt_p < MIN_LEN)
        begin
            status_p = ST_TOO_SHORT;
        end
        else if (mal_p || !complete)
        begin
            status_p = ST_MALFORMED;
        end
        else if (year_p < BASE_YEAR)
        begin
            status_p = ST_PRE_EPOCH;
        end
        else if ((month_p < MONTH_FIRST) || (month_p > MONTH_LAST))
        begin
            status_p = ST_BAD_MONTH;
        end
        else
        begin
            status_p = ST_OK;
        end
    end

    always_comb
    begin
        acc_next    = acc_reg;
        dcnt_next   = dcnt_reg;
        cnt_next    = cnt_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        mal_next    = mal_reg;
        if (take_last)
        begin
            acc_next    = '0;
            dcnt_next   = '0;
            cnt_next    = '0;
            year_next   = '0;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            mal_next    = 1'b0;
        end
        else if (take)
        begin
            acc_next    = acc_p;
            dcnt_next   = dcnt_p;
            cnt_next    = cnt_p;
            year_next   = year_p;
            month_next  = month_p;
            day_next    = day_p;
            hour_next   = hour_p;
            minute_next = minute_p;
            mal_next    = mal_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_YEAR;
            acc_reg    <= '0;
            dcnt_reg   <= '0;
            cnt_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            mal_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            dcnt_reg   <= dcnt_next;
            cnt_reg    <= cnt_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            mal_reg    <= mal_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: snapshot of the finished fields
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take_last)
        begin
            a_status_reg <= status_p;
            a_year_reg   <= year_p;
            a_month_reg  <= month_p;
            a_day_reg    <= day_p;
            a_hour_reg   <= hour_p;
            a_minute_reg <= minute_p;
            a_sec_reg    <= acc_p[6:0];
        end
    end

    // Leap counts through the previous year, by reciprocal multiplication.
    always_comb
    begin
        a_ym1      = a_year_reg - 14'd1;
        a_prod_ym1 = 27'(a_ym1) * 27'(RECIP_100);
        a_prod_y   = 27'(a_year_reg) * 27'(RECIP_100);
        a_prod_q4  = 25'(a_ym1[13:2]) * 25'(RECIP_100);
    end

    always_ff @(posedge clk)
    begin
        if (a_vld_reg && b_ready)
        begin
            b_status_reg <= a_status_reg;
            b_year_reg   <= a_year_reg;
            b_month_reg  <= a_month_reg;
            b_day_reg    <= a_day_reg;
            b_hour_reg   <= a_hour_reg;
            b_minute_reg <= a_minute_reg;
            b_sec_reg    <= a_sec_reg;
            b_q4_reg     <= a_ym1[13:2];
            b_q100_reg   <= a_prod_ym1[RECIP_SHIFT +: 8];
            b_q400_reg   <= a_prod_q4[RECIP_SHIFT +: 6];
            b_yq100_reg  <= a_prod_y[RECIP_SHIFT +: 8];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: day number and time of day
    // ------------------------------------------------------------------
    always_comb
    begin
        b_rem100 = b_year_reg - 14'(22'(b_yq100_reg) * 22'd100);
        // Divisible by 4, and either not by 100 or by 400.
        b_leap   = (b_year_reg[1:0] == 2'b00) &&
                   ((b_rem100 != 14'd0) || (b_yq100_reg[1:0] == 2'b00));
        b_yoff   = b_year_reg - BASE_YEAR;
        b_dpos   = 23'(b_yoff) * 23'd365
                 + 23'(b_q4_reg)
                 + 23'(b_q400_reg)
                 + 23'(days_before_month(b_month_reg[3:0]))
                 + 23'(((b_month_reg >= MONTH_MARCH) && b_leap) ? 1'b1 : 1'b0)
                 + 23'(b_day_reg);
        b_dneg   = 24'(b_q100_reg) + 24'(LEAPS_BEFORE_BASE) + 24'd1;
        b_days   = $signed({1'b0, b_dpos}) - $signed(b_dneg);
        b_tod    = 19'(b_hour_reg) * 19'd3600
                 + 19'(b_minute_reg) * 19'd60
                 + 19'(b_sec_reg);
    end

    always_ff @(posedge clk)
    begin
        if (b_vld_reg && c_ready)
        begin
            c_status_reg <= b_status_reg;
            c_days_reg   <= b_days;
            c_tod_reg    <= b_tod;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: seconds total into the output register
    // ------------------------------------------------------------------
    always_comb
    begin
        c_total = 42'(c_days_reg) * $signed(42'd86400)
                + $signed({23'd0, c_tod_reg});
        o_data_next.status = c_status_reg;
        // A zero day in January 1970 can fall before the epoch; that reads 0.
        if ((c_status_reg != ST_OK) || c_total[41])
        begin
            o_data_next.epoch_seconds = '0;
        end
        else
        begin
            o_data_next.epoch_seconds = c_total[37:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_vld_reg && o_ready)
        begin
            o_data_reg <= o_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_vld_reg <= take_last;
            end
            if (b_ready)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_ready)
            begin
                c_vld_reg <= b_vld_reg;
            end
            if (o_ready)
            begin
                o_vld_reg <= c_vld_reg;
            end
        end
    end

    assign ep_valid = o_vld_reg;
    assign ep_data  = o_data_reg;

endmodule
